// ===== hw/rtl/b2da_pkg.sv =====
// shared types and constants for the binary to decimal ascii emitter
// no dependencies; used by the cell, chain and core rtl files through scoped names

package b2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_W);

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef logic [3:0] digit_t;

    // control from the sequencer to the digit chain
    typedef struct packed {
        logic clear;
        logic shift;
    } chain_ctrl_t;

endpackage

// ===== hw/rtl/b2da_cell.sv =====
// one bcd digit cell of the shift-and-add-3 chain
// depends on b2da_pkg

module b2da_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  b2da_pkg::chain_ctrl_t ctrl,
    input  logic                  carry_in,
    output logic                  carry_out,
    output b2da_pkg::digit_t      digit
);

    b2da_pkg::digit_t digit_reg;
    b2da_pkg::digit_t digit_next;
    b2da_pkg::digit_t adjusted;

    // digit of five or more gets three added so the shift doubles it in decimal
    assign adjusted  = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adjusted[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adjusted[2:0], carry_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== hw/rtl/b2da_chain.sv =====
// row of bcd digit cells, least significant digit at index 0
// depends on b2da_pkg and b2da_cell

module b2da_chain
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  b2da_pkg::chain_ctrl_t ctrl,
    input  logic                  bit_in,
    output b2da_pkg::digit_t      digits [b2da_pkg::NUM_DIGITS]
);

    logic carry [b2da_pkg::NUM_DIGITS+1];

    assign carry[0] = bit_in;

    genvar i;
    generate
        for (i = 0; i < b2da_pkg::NUM_DIGITS; i++)
        begin : g_cell
            b2da_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (carry[i]),
                .carry_out (carry[i+1]),
                .digit     (digits[i])
            );
        end
    endgenerate

    // carry out of the top digit never occurs for a 32-bit value
    logic unused_top_carry;
    assign unused_top_carry = carry[b2da_pkg::NUM_DIGITS];

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_emitter_core.sv =====
// top level of the binary to decimal ascii emitter
// depends on b2da_pkg and b2da_chain (which holds the b2da_cell row)
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    value[31:0], mode
// out      output     out_valid/out_stall  ascii_char[5:0], last
//
// one number is converted by shifting value, most significant bit first,
// through the shift-and-add-3 digit chain; the leading digit is then located,
// and then the characters (1 to 10 characters) are loaded out one after
// another while out_stall is low
// in_stall stays high from the accepted transfer until the last character
// is loaded into the output register; that character may still wait there
// while the next number is taken in
// reset clears the sequencer and the output valid; out_stall freezes
// only the character output, the conversion itself never stalls

module binary_to_decimal_ascii_emitter_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    input  logic        mode,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  ascii_char,
    output logic        last
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                           state_reg;
    logic [b2da_pkg::VALUE_W-1:0]     value_reg;
    logic                             mode_reg;
    logic [b2da_pkg::CNT_W-1:0]       count_reg;
    logic [b2da_pkg::IDX_W-1:0]       idx_reg;
    logic                             out_valid_reg;
    logic [5:0]                       ascii_char_reg;
    logic                             last_reg;

    b2da_pkg::chain_ctrl_t            chain_ctrl;
    b2da_pkg::digit_t                 digits [b2da_pkg::NUM_DIGITS];
    logic [b2da_pkg::IDX_W-1:0]       top_idx;
    logic [b2da_pkg::IDX_W-1:0]       first_idx;
    logic                             in_xfer;
    logic                             load_out;

    assign in_xfer = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // output register may take a new character when empty or being drained
    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // chain is cleared on a new number and shifts once per bit afterwards
    assign chain_ctrl.clear = in_xfer;
    assign chain_ctrl.shift = (state_reg == ST_CONV);

    b2da_chain u_chain
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (chain_ctrl),
        .bit_in (value_reg[b2da_pkg::VALUE_W-1]),
        .digits (digits)
    );

    // highest nonzero digit, zero when the whole value is zero
    always_comb
    begin
        top_idx = '0;
        for (int i = 1; i < b2da_pkg::NUM_DIGITS; i++)
        begin
            if (digits[i] != '0)
            begin
                top_idx = b2da_pkg::IDX_W'(i);
            end
        end
    end

    // padded mode shows at least two digits
    assign first_idx = (!mode_reg && top_idx == '0) ? b2da_pkg::IDX_W'(1) : top_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            value_reg      <= '0;
            mode_reg       <= 1'b0;
            ascii_char_reg <= b2da_pkg::ASCII_ZERO;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        value_reg <= value;
                        mode_reg  <= mode;
                        count_reg <= '0;
                        state_reg <= ST_CONV;
                    end
                end

                ST_CONV:
                begin
                    value_reg <= {value_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == b2da_pkg::CNT_W'(b2da_pkg::VALUE_W - 1))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end

                // digits are final here, pick the leading one
                ST_SCAN:
                begin
                    idx_reg   <= first_idx;
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        out_valid_reg  <= 1'b1;
                        ascii_char_reg <= b2da_pkg::ASCII_ZERO + {2'b00, digits[idx_reg]};
                        last_reg       <= (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = ascii_char_reg;
    assign last       = last_reg;

endmodule

// ===== hw/rtl/b2da_checker.sv =====
// port-level checks for the binary to decimal ascii emitter
// depends on binary_to_decimal_ascii_emitter_core; bound to it at the end

module b2da_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] value,
    input logic        mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  ascii_char,
    input logic        last
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ascii_char) && $stable(last))
        else $error("stalled output character changed");

    // only decimal digit codes come out
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_char >= 6'd48) && (ascii_char <= 6'd57))
        else $error("output is not a decimal digit");

    // conversion keeps the input side busy late in the bit sweep (checked at a single point)
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##31 in_stall)
        else $error("input taken again during conversion");

    // no character comes out right after an input transfer unless one was already waiting
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("character appeared right after an input transfer");

endmodule

bind binary_to_decimal_ascii_emitter_core b2da_checker u_b2da_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .last       (last)
);
